// ===== hdl/cbts_pkg.sv =====
// Package for the CAN bit timing and synchronization unit.
// Item types, segment codes, register indexes and reset values; no dependencies.
`timescale 1ns / 1ps

package cbts_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TSEG1_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE2_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_WIDTH    = 2'd2;

  // Register reset values
  localparam logic [4:0] TSEG1_LENGTH_RST  = 5'd7;
  localparam logic [4:0] PHASE2_LENGTH_RST = 5'd4;
  localparam logic [2:0] JUMP_WIDTH_RST    = 3'd1;

  // Segment codes reported with each item
  localparam logic [1:0] SEG_SYNC  = 2'd0;
  localparam logic [1:0] SEG_TSEG1 = 2'd1;
  localparam logic [1:0] SEG_TSEG2 = 2'd2;

  typedef struct packed {
    logic quantum_tick;
    logic bus_level;
    logic tx_bit;
    logic idle_flag;
  } in_item_t;

  typedef struct packed {
    logic       rx_bit;
    logic       drive_bit;
    logic       smp_mark;
    logic       wr_mark;
    logic       bit_done;
    logic [1:0] segment;
    logic       hard_sync_done;
    logic       resync_done;
  } out_item_t;

  // Timing registers as seen by the core
  typedef struct packed {
    logic [4:0] tseg1_length;
    logic [4:0] phase2_length;
    logic [2:0] jump_width;
  } timing_cfg_t;

endpackage

// ===== hdl/cbts_core.sv =====
// Bit timing state and per-item next-state logic of the CAN bit timing unit.
// Depends on cbts_pkg for item and configuration types.
`timescale 1ns / 1ps

module cbts_core #(
  parameter int unsigned CW = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  cbts_pkg::in_item_t   item,
  input  cbts_pkg::timing_cfg_t cfg,
  output cbts_pkg::out_item_t  result
);

  typedef enum logic [1:0] {
    ST_SYNC  = 2'd0,
    ST_TSEG1 = 2'd1,
    ST_TSEG2 = 2'd2
  } seg_state_t;

  localparam logic signed [CW-1:0] ONE  = CW'(1);
  localparam logic signed [CW-1:0] ZERO = '0;

  seg_state_t seg_r, seg_nxt;
  logic signed [CW-1:0] qc_r, qc_nxt;
  logic signed [CW-1:0] t1e_r, t1e_nxt;
  logic signed [CW-1:0] t2e_r, t2e_nxt;
  logic corr_r, corr_nxt;
  logic hard_r, hard_nxt;
  logic rsp_r, rsp_nxt;
  logic prev_r, prev_nxt;
  logic samp_r, samp_nxt;
  logic wrp_r, wrp_nxt;

  // Next-state and result for one item
  always_comb begin
    logic signed [CW-1:0] jx;
    logic signed [CW-1:0] p2neg;
    logic signed [CW-1:0] pc;
    logic signed [CW-1:0] lim;
    logic signed [CW-1:0] npc;
    logic signed [CW-1:0] err;
    logic                 err_valid;
    logic                 start;
    logic                 done;
    logic                 hs;
    logic                 rs;
    logic [1:0]           seg_out;

    jx        = CW'(cfg.jump_width);
    p2neg     = -CW'(cfg.phase2_length);
    pc        = qc_r;
    lim       = ZERO;
    npc       = ZERO;
    err       = ZERO;
    err_valid = 1'b0;
    start     = 1'b0;
    done      = 1'b0;
    hs        = 1'b0;
    rs        = 1'b0;
    seg_out   = cbts_pkg::SEG_SYNC;

    seg_nxt  = seg_r;
    qc_nxt   = qc_r;
    t1e_nxt  = t1e_r;
    t2e_nxt  = t2e_r;
    corr_nxt = corr_r;
    hard_nxt = hard_r;
    rsp_nxt  = rsp_r;
    prev_nxt = prev_r;
    samp_nxt = samp_r;
    wrp_nxt  = wrp_r;

    if (item.quantum_tick) begin
      // recessive-to-dominant edge arms hard sync or resync
      if (!item.bus_level && prev_r) begin
        hard_nxt = item.idle_flag;
        rsp_nxt  = !item.idle_flag;
        prev_nxt = 1'b0;
      end

      if (hard_nxt) begin
        hard_nxt = 1'b0;
        corr_nxt = 1'b1;
        hs       = 1'b1;
        start    = 1'b1;
      end else begin
        unique case (seg_r)
          ST_TSEG1: begin
            seg_out = cbts_pkg::SEG_TSEG1;
            wrp_nxt = 1'b0;
            lim     = t1e_r;
            if (pc < lim) pc = pc + ONE;
            // resync lengthens TSEG1
            if (rsp_nxt) begin
              rsp_nxt  = 1'b0;
              corr_nxt = 1'b1;
              rs       = 1'b1;
              lim      = lim + ((jx < pc) ? jx : pc);
              t1e_nxt  = lim;
            end
            if (pc == lim) begin
              qc_nxt  = p2neg;
              seg_nxt = ST_TSEG2;
            end else begin
              qc_nxt = pc;
            end
          end
          ST_TSEG2: begin
            seg_out = cbts_pkg::SEG_TSEG2;
            lim     = t2e_r;
            // first quantum of phase segment 2 is the sample point
            if (pc == p2neg) begin
              prev_nxt = item.bus_level;
              samp_nxt = 1'b1;
            end else begin
              samp_nxt = 1'b0;
            end
            // resync shortens TSEG2
            if (rsp_nxt) begin
              rsp_nxt   = 1'b0;
              rs        = 1'b1;
              npc       = -pc;
              err       = (jx < npc) ? jx : npc;
              lim       = lim - err;
              t2e_nxt   = lim;
              corr_nxt  = ((pc + ONE) == lim);
              err_valid = 1'b1;
            end
            if (pc < lim) pc = pc + ONE;
            qc_nxt = pc;
            if (pc == lim) begin
              // whole remainder absorbed: skip the sync segment
              if (err_valid && (err == -pc) && !corr_nxt) start = 1'b1;
              else seg_nxt = ST_SYNC;
              corr_nxt = 1'b0;
              done     = 1'b1;
            end
          end
          default: begin
            start = 1'b1;
          end
        endcase
      end

      // bit start
      if (start) begin
        qc_nxt   = ZERO;
        wrp_nxt  = 1'b1;
        samp_nxt = 1'b0;
        seg_nxt  = ST_TSEG1;
        t1e_nxt  = CW'(cfg.tseg1_length);
        t2e_nxt  = ZERO;
      end
    end

    result.rx_bit         = item.bus_level;
    result.drive_bit      = item.tx_bit;
    result.smp_mark       = samp_nxt;
    result.wr_mark        = wrp_nxt;
    result.bit_done       = done;
    result.segment        = seg_out;
    result.hard_sync_done = hs;
    result.resync_done    = rs;
  end

  // Timing state, updated once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r  <= ST_SYNC;
      qc_r   <= ZERO;
      t1e_r  <= ZERO;
      t2e_r  <= ZERO;
      corr_r <= 1'b0;
      hard_r <= 1'b0;
      rsp_r  <= 1'b0;
      prev_r <= 1'b1;
      samp_r <= 1'b0;
      wrp_r  <= 1'b0;
    end else if (en) begin
      seg_r  <= seg_nxt;
      qc_r   <= qc_nxt;
      t1e_r  <= t1e_nxt;
      t2e_r  <= t2e_nxt;
      corr_r <= corr_nxt;
      hard_r <= hard_nxt;
      rsp_r  <= rsp_nxt;
      prev_r <= prev_nxt;
      samp_r <= samp_nxt;
      wrp_r  <= wrp_nxt;
    end
  end

endmodule

// ===== hdl/can_bit_timing_sync_unit.sv =====
// CAN bit timing and synchronization unit: top level with input, output and
// configuration registers. Depends on cbts_pkg and cbts_core.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall / in_item): one item per clock of the
//   controller while in_stall is low; quantum_tick marks a time quantum, the
//   other bits are the bus level, the bit to drive and the bus idle flag.
//   Result channel (out_valid / out_stall / out_item): exactly one result item
//   per input item, in order: pass-through bits, sample and writing points,
//   end of bit, segment code and sync pulses.
//   Configuration (cfg_we / cfg_index / cfg_data): tseg1_length, phase2_length,
//   jump_width; write only while no item is in flight.
//   Path: an item held in the input register goes through the timing state
//   update into the output register. Throughput: one item per cycle while
//   out_stall is low.
//   Reset (synchronous, rst_n low): both registers empty, sync segment,
//   counters zero, last level recessive, registers at 7 / 4 / 1.
//   Stall: a result held by out_stall stays stable; the input register still
//   takes one more item, after which in_stall rises until the result drains.

module can_bit_timing_sync_unit #(
  parameter int unsigned COUNTER_BITS = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  cbts_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output cbts_pkg::out_item_t               out_item,
  input  logic                              cfg_we,
  input  logic [cbts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cbts_pkg::CFG_DATA_W-1:0]   cfg_data
);

  cbts_pkg::timing_cfg_t cfg_r;
  cbts_pkg::in_item_t    in_r;
  logic                  in_vld_r;
  cbts_pkg::out_item_t   out_r;
  cbts_pkg::out_item_t   result;
  logic                  out_vld_r;
  logic                  advance;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tseg1_length  <= cbts_pkg::TSEG1_LENGTH_RST;
      cfg_r.phase2_length <= cbts_pkg::PHASE2_LENGTH_RST;
      cfg_r.jump_width    <= cbts_pkg::JUMP_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cbts_pkg::CFG_TSEG1_LENGTH:  cfg_r.tseg1_length  <= cfg_data;
        cbts_pkg::CFG_PHASE2_LENGTH: cfg_r.phase2_length <= cfg_data;
        cbts_pkg::CFG_JUMP_WIDTH:    cfg_r.jump_width    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Handshake: an item moves on when the output register is free or drains
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_r <= in_item;
    end
  end

  cbts_core #(
    .CW (COUNTER_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (advance),
    .item   (in_r),
    .cfg    (cfg_r),
    .result (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  // A processed item always lands in the output register
  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("processed item did not reach the output register");

  // The input side only stalls while it holds an item
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("input stalled while empty");

  // End of bit is only reported from phase segment 2
  a_done_in_tseg2: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.bit_done) |-> (out_item.segment == cbts_pkg::SEG_TSEG2))
    else $error("bit end outside phase segment 2");

  // Hard sync and resync never apply to the same quantum
  a_sync_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.hard_sync_done && out_item.resync_done))
    else $error("hard sync and resync in one quantum");
`endif

endmodule
